// File: design/qpc_pkg.sv
// ----------------------------------------------------------------------------
// qpc_pkg
// Shared types and constants of the quadrature position counter.
// ----------------------------------------------------------------------------
`default_nettype none

package qpc_pkg;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned REVS_W      = 21;
  localparam int unsigned STEPS_W     = 30;
  localparam int unsigned FILT_W      = 10;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_DATA_W   = 40;  // a, b, load value, padded to bytes
  localparam int unsigned OUT_DATA_W  = 88;  // position, revs, steps, padded

  localparam int unsigned COUNTS_PER_REV = 2048;
  localparam int unsigned STEPS_PER_REV  = 200;
  localparam logic [FILT_W-1:0] FILTER_RESET = FILT_W'(1000);

  // product of position and steps per revolution, signed
  localparam int unsigned MUL_W  = 18;
  localparam int unsigned PROD_W = POS_W + MUL_W;

  localparam logic signed [MUL_W-1:0]  STEPS_MUL   = MUL_W'(STEPS_PER_REV);
  localparam logic signed [POS_W-1:0]  CPR_DIV_POS = POS_W'(COUNTS_PER_REV);
  localparam logic signed [PROD_W-1:0] CPR_DIV_PRD = PROD_W'(COUNTS_PER_REV);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOAD   = 2'd2
  } op_t;

  // filter status toward the counter
  typedef struct packed {
    logic level;  // accepted level before this sample
    logic edge_hit;
  } filt_t;

endpackage

`default_nettype wire

// File: design/quadrature_position_counter_unit.sv
// ----------------------------------------------------------------------------
// quadrature_position_counter_unit
// 4x quadrature decoder with per-pin glitch filters and position scaling.
// ----------------------------------------------------------------------------
//  channel  | signals                          | contents
//  s_axis   | tvalid tready tdata[39:0] tuser  | op; a, b, load value
//  m_axis   | tvalid tready tdata[87:0]        | position, revs, steps
//  cfg      | valid ready data[9:0]            | filter_ticks
//
// One item per cycle sustained while m_axis_tready stays high. The input
// register loads at the input transfer; the count, multiply and divide/output
// registers follow it in that order, each loading from the one before.
// Each stage loads when empty or when the stage after it moves, so an
// output stall fills the pipeline before s_axis_tready drops.
// rst (synchronous) clears position, filters and sets filter_ticks to 1000.
// cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_position_counter_unit
  import qpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [0] a_level, [1] b_level, [33:2] load_value, zero pad above
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] op
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [31:0] position, [52:32] revs, [82:53] steps, zero pad above
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [FILT_W-1:0]     cfg_data
);

  logic [FILT_W-1:0] filter_ticks;

  // input register
  logic             v_in;
  op_t              op_in;
  logic             a_in;
  logic             b_in;
  logic [POS_W-1:0] load_in;

  // count stage
  logic             v_cnt;
  logic [POS_W-1:0] count_value;
  logic [POS_W-1:0] count_next;

  logic  en_in;
  logic  en_cnt;
  logic  scale_ready;
  logic  adv;
  logic  sample;
  filt_t a_st;
  filt_t b_st;
  logic [POS_W-1:0] delta_a;
  logic [POS_W-1:0] delta_b;

  assign cfg_ready = 1'b1;

  assign en_cnt        = !v_cnt || scale_ready;
  assign en_in         = !v_in || en_cnt;
  assign s_axis_tready = en_in;

  assign adv    = v_in && en_cnt;
  assign sample = adv && (op_in == OP_SAMPLE);

  qpc_filter u_filt_a (
    .clk          (clk),
    .rst          (rst),
    .step         (sample),
    .raw          (a_in),
    .filter_ticks (filter_ticks),
    .status       (a_st)
  );

  qpc_filter u_filt_b (
    .clk          (clk),
    .rst          (rst),
    .step         (sample),
    .raw          (b_in),
    .filter_ticks (filter_ticks),
    .status       (b_st)
  );

  // A edge counts up when its new level matches old B; B edge counts up
  // when old levels of A and B are equal.
  always_comb begin
    delta_a = '0;
    delta_b = '0;
    if (a_st.edge_hit) begin
      delta_a = ((!a_st.level) == b_st.level) ? POS_W'(1) : '1;
    end
    if (b_st.edge_hit) begin
      delta_b = (a_st.level == b_st.level) ? POS_W'(1) : '1;
    end
    case (op_in)
      OP_SAMPLE: count_next = count_value + delta_a + delta_b;
      OP_CLEAR:  count_next = '0;
      OP_LOAD:   count_next = load_in;
      default:   count_next = count_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_ticks <= FILTER_RESET;
      v_in         <= 1'b0;
      v_cnt        <= 1'b0;
      count_value  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        filter_ticks <= cfg_data;
      end
      if (en_in) begin
        v_in <= s_axis_tvalid;
      end
      if (en_cnt) begin
        v_cnt <= v_in;
      end
      if (adv) begin
        count_value <= count_next;
      end
    end
    if (en_in && s_axis_tvalid) begin
      op_in   <= op_t'(s_axis_tuser);
      a_in    <= s_axis_tdata[0];
      b_in    <= s_axis_tdata[1];
      load_in <= s_axis_tdata[POS_W+1:2];
    end
  end

  // count_value only moves when the count stage loads, so it is the payload
  qpc_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v_cnt),
    .in_ready      (scale_ready),
    .in_pos        ($signed(count_value)),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_edge_only_on_sample: assert property (@(posedge clk) disable iff (rst)
    (a_st.edge_hit || b_st.edge_hit) |-> sample)
    else $error("filter edge outside a sample transfer");

  clear_zeroes_count: assert property (@(posedge clk) disable iff (rst)
    (adv && op_in == OP_CLEAR) |=> (count_value == '0))
    else $error("clear did not zero the position");

  count_holds_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(count_value))
    else $error("position moved without an item");

  sample_step_bounded: assert property (@(posedge clk) disable iff (rst)
    sample |=> ((count_value - $past(count_value)) == POS_W'(0) ||
                (count_value - $past(count_value)) == POS_W'(1) ||
                (count_value - $past(count_value)) == POS_W'(2) ||
                (count_value + POS_W'(1)) == $past(count_value) ||
                (count_value + POS_W'(2)) == $past(count_value)))
    else $error("sample moved position by more than two counts");

  empty_input_ready: assert property (@(posedge clk) disable iff (rst)
    !v_in |-> s_axis_tready)
    else $error("empty input register not ready");

endmodule

`default_nettype wire

// File: design/qpc_filter.sv
// ----------------------------------------------------------------------------
// qpc_filter
// Glitch filter for one encoder pin: accepts a new level once it has held.
// ----------------------------------------------------------------------------
`default_nettype none

module qpc_filter
  import qpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              raw,
  input  wire logic [FILT_W-1:0] filter_ticks,
  output filt_t                  status
);

  logic              level;
  logic [FILT_W-1:0] hold;
  logic              differs;
  logic              accept;

  assign differs = raw != level;
  assign accept  = differs && (hold >= filter_ticks);

  assign status.level    = level;
  assign status.edge_hit = step && accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b0;
      hold  <= '0;
    end else if (step) begin
      if (!differs || accept) begin
        hold <= '0;
      end else begin
        // hold < filter_ticks here, so it cannot wrap
        hold <= hold + FILT_W'(1);
      end
      if (accept) begin
        level <= raw;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/qpc_scale.sv
// ----------------------------------------------------------------------------
// qpc_scale
// Two-stage scaling of the position into revolutions and motor steps.
// ----------------------------------------------------------------------------
`default_nettype none

module qpc_scale
  import qpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [POS_W-1:0] in_pos,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]        m_axis_tdata
);

  logic                     v_mul;
  logic signed [POS_W-1:0]  pos_mul;
  logic signed [PROD_W-1:0] prod_mul;
  logic                     en_mul;
  logic                     en_out;

  logic signed [POS_W-1:0]  revs_full;
  logic signed [PROD_W-1:0] steps_full;

  logic [POS_W-1:0]   out_pos;
  logic [REVS_W-1:0]  out_revs;
  logic [STEPS_W-1:0] out_steps;

  assign en_out   = !m_axis_tvalid || m_axis_tready;
  assign en_mul   = !v_mul || en_out;
  assign in_ready = en_mul;

  // signed division by a constant truncates toward zero
  assign revs_full  = pos_mul / CPR_DIV_POS;
  assign steps_full = prod_mul / CPR_DIV_PRD;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en_mul) begin
        v_mul <= in_valid;
      end
      if (en_out) begin
        m_axis_tvalid <= v_mul;
      end
    end
    if (en_mul && in_valid) begin
      pos_mul  <= in_pos;
      prod_mul <= PROD_W'(in_pos) * PROD_W'(STEPS_MUL);
    end
    if (en_out && v_mul) begin
      out_pos   <= pos_mul;
      out_revs  <= revs_full[REVS_W-1:0];
      out_steps <= steps_full[STEPS_W-1:0];
    end
  end

  assign m_axis_tdata = {
    (OUT_DATA_W - POS_W - REVS_W - STEPS_W)'(0), out_steps, out_revs, out_pos
  };

endmodule

`default_nettype wire

// File: bench/tb_quadrature_position_counter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_position_counter_unit
// Drives encoder samples, clears and loads through the input stream and checks
// every position, revolution and step count against a cycle-free counter model
// kept in the bench. A short table covers reset, extremes, wrap, count
// directions and glitch rejection. Random quadrature walks with glitches follow,
// run at several filter settings.
// ----------------------------------------------------------------------------

module tb_quadrature_position_counter_unit;
  import qpc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES = 8;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [REVS_W-1:0]  revs;
    logic [STEPS_W-1:0] steps;
  } qpc_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [OP_W-1:0] op;
    bit              a;
    bit              b;
    int              value;  // load value, or filter_ticks on a cfg row
    bit              typed;
    int              t_pos;
    int              t_revs;
    int              t_steps;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [0] a_level, [1] b_level, [33:2] load_value, zero pad above
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] op
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] position, [52:32] revs, [82:53] steps, zero pad above
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [FILT_W-1:0]     cfg_data = '0;

  quadrature_position_counter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // counter model state
  logic [POS_W-1:0]  count_m;
  bit                a_filt_m;
  bit                b_filt_m;
  logic [FILT_W-1:0] a_hold_m;
  logic [FILT_W-1:0] b_hold_m;
  logic [FILT_W-1:0] filter_ticks_m;

  qpc_result_t expected_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;  // no idling on either side while set

  // random walk state
  int unsigned walk_idx = 0;
  bit          walk_up = 1'b1;
  int unsigned hold_left = 0;

  dir_row_t dir_rows [20] = '{
    '{ROW_ITEM, OP_SAMPLE, 0, 0, 0, 1, 0, 0, 0},
    // short glitch on both pins at filter 1000: rejected
    '{ROW_ITEM, OP_SAMPLE, 1, 1, 32'h5A5A5A5A, 1, 0, 0, 0},
    '{ROW_ITEM, OP_LOAD, 0, 0, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 1048575, 209715199},
    '{ROW_ITEM, OP_LOAD, 1, 1, 32'h80000000, 1, 32'h80000000, -1048576, -209715200},
    // small negatives truncate toward zero
    '{ROW_ITEM, OP_LOAD, 0, 1, -1, 1, -1, 0, 0},
    '{ROW_ITEM, OP_LOAD, 1, 0, -2048, 1, -2048, -1, -200},
    '{ROW_ITEM, OP_LOAD, 0, 0, 2047, 1, 2047, 0, 199},
    '{ROW_ITEM, OP_LOAD, 0, 0, -11, 1, -11, 0, -1},
    '{ROW_ITEM, OP_CLEAR, 1, 1, 32'hFFFFFFFF, 1, 0, 0, 0},
    '{ROW_ITEM, OP_UNUSED, 1, 1, 32'h12345678, 1, 0, 0, 0},
    '{ROW_CFG, OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, OP_LOAD, 0, 0, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 1048575, 209715199},
    // B rise with A low counts up and wraps to the minimum
    '{ROW_ITEM, OP_SAMPLE, 0, 1, 0, 1, 32'h80000000, -1048576, -209715200},
    '{ROW_ITEM, OP_SAMPLE, 1, 1, 0, 0, 0, 0, 0},
    // both pins fall on one tick
    '{ROW_ITEM, OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, OP_SAMPLE, 1, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, OP_SAMPLE, 1, 1, 0, 0, 0, 0, 0},
    '{ROW_ITEM, OP_SAMPLE, 0, 1, 0, 0, 0, 0, 0},
    '{ROW_ITEM, OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, OP_SAMPLE, 0, 0, 1023, 0, 0, 0, 0}
  };

  // filter 1023 leaves holds pending, the lower settings after it accept them
  int phase_filter [N_PHASES] = '{1023, 3, 0, 1, 2, 7, 1000, 0};
  int phase_items  [N_PHASES] = '{300, 200, 250, 200, 150, 150, 100, 100};

  function automatic bit pin_filter(input bit raw, inout bit level,
                                    inout logic [FILT_W-1:0] hold);
    if (raw == level) begin
      hold = '0;
      return 1'b0;
    end
    if (hold >= filter_ticks_m) begin
      level = raw;
      hold = '0;
      return 1'b1;
    end
    hold = hold + 1'b1;
    return 1'b0;
  endfunction

  task automatic step_counter(input logic [OP_W-1:0] op, input bit a, input bit b,
                              input logic [POS_W-1:0] load, output qpc_result_t res);
    bit     a_old;
    bit     b_old;
    bit     a_edge;
    bit     b_edge;
    longint pos;
    longint cpr;
    longint spr;
    cpr = COUNTS_PER_REV;
    spr = STEPS_PER_REV;
    if (op == OP_SAMPLE) begin
      a_old = a_filt_m;
      b_old = b_filt_m;
      a_edge = pin_filter(a, a_filt_m, a_hold_m);
      b_edge = pin_filter(b, b_filt_m, b_hold_m);
      // edges are judged against the other pin's level from before this tick
      if (a_edge) count_m = (a_filt_m == b_old) ? count_m + 1 : count_m - 1;
      if (b_edge) count_m = (b_filt_m != a_old) ? count_m + 1 : count_m - 1;
    end else if (op == OP_CLEAR) begin
      count_m = '0;
    end else if (op == OP_LOAD) begin
      count_m = load;
    end
    pos = longint'($signed(count_m));
    res.position = count_m;
    res.revs     = REVS_W'(pos / cpr);
    res.steps    = STEPS_W'((pos * spr) / cpr);
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input bit a, input bit b,
                           input logic [POS_W-1:0] load, input bit typed,
                           input qpc_result_t typed_res);
    qpc_result_t res;
    if (!quiet && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({load, b, a});
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    step_counter(op, a, b, load, res);
    expected_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_filter_ticks(input logic [FILT_W-1:0] ticks);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    filter_ticks_m = ticks;
  endtask

  function automatic logic [1:0] walk_levels(input int unsigned idx);
    case (idx % 4)
      0: return 2'b00;  // {b, a}
      1: return 2'b01;
      2: return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  task automatic send_random(input int filt);
    logic [OP_W-1:0]  op;
    logic [1:0]       ba;
    logic [POS_W-1:0] load;
    int unsigned      k;
    int unsigned      hold_max;
    qpc_result_t      unused_res;
    unused_res = '0;
    k = $urandom_range(0, 99);
    load = $urandom;
    ba = 2'($urandom);
    if (k < 3) begin
      op = OP_CLEAR;
    end else if (k < 7) begin
      op = OP_LOAD;
      case ($urandom_range(0, 7))
        0: load = 32'h7FFFFFFF;
        1: load = 32'h80000000;
        2: load = 32'hFFFFFFFF;
        3: load = 32'($signed(-$urandom_range(0, 3000)));
        default: ;
      endcase
    end else if (k < 9) begin
      op = OP_UNUSED;
    end else begin
      op = OP_SAMPLE;
      hold_max = (filt > 100) ? 400 : filt + 3;
      if (hold_left == 0) begin
        if ($urandom_range(0, 9) == 0) walk_up = !walk_up;
        // occasional jump of both pins at once
        if ($urandom_range(0, 19) == 0) walk_idx = walk_idx + 2;
        else walk_idx = walk_up ? walk_idx + 1 : walk_idx + 3;
        hold_left = $urandom_range(0, hold_max);
      end else begin
        hold_left = hold_left - 1;
      end
      ba = walk_levels(walk_idx);
      if ($urandom_range(0, 19) == 0) ba = ba ^ (2'b01 << $urandom_range(0, 1));
    end
    send_item(op, ba[0], ba[1], load, 1'b0, unused_res);
  endtask

  // result checker
  always @(posedge clk) begin
    qpc_result_t got;
    qpc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.position = m_axis_tdata[31:0];
      got.revs     = m_axis_tdata[52:32];
      got.steps    = m_axis_tdata[82:53];
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: position %0d", $signed(got.position));
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d",
                 $signed(want.position), $signed(got.position));
          errors++;
        end
        if (got.revs !== want.revs) begin
          $error("revs: expected %0d, got %0d",
                 $signed(want.revs), $signed(got.revs));
          errors++;
        end
        if (got.steps !== want.steps) begin
          $error("steps: expected %0d, got %0d",
                 $signed(want.steps), $signed(got.steps));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    qpc_result_t typed_res;
    count_m = '0;
    a_filt_m = 1'b0;
    b_filt_m = 1'b0;
    a_hold_m = '0;
    b_hold_m = '0;
    filter_ticks_m = FILTER_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_filter_ticks(FILT_W'(dir_rows[i].value));
      end else begin
        typed_res.position = dir_rows[i].t_pos;
        typed_res.revs     = REVS_W'(dir_rows[i].t_revs);
        typed_res.steps    = STEPS_W'(dir_rows[i].t_steps);
        send_item(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].value,
                  dir_rows[i].typed, typed_res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_filter_ticks(FILT_W'(phase_filter[p]));
      quiet = (p == 2);
      for (int n = 0; n < phase_items[p]; n++) begin
        send_random(phase_filter[p]);
        // let the pipeline run dry once mid-run
        if (p == 1 && n == phase_items[p] / 2) drain_results();
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/qpc_pkg.sv
design/qpc_filter.sv
design/qpc_scale.sv
design/quadrature_position_counter_unit.sv
bench/tb_quadrature_position_counter_unit.sv
